// ----- rtl/nlms_echo_canceller_assert.svh -----
// Assertion macros for the echo canceller.
`ifndef NLMS_ECHO_CANCELLER_ASSERT_SVH
`define NLMS_ECHO_CANCELLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NEC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/nec_pkg.sv -----
// Shared constants and helpers for the echo canceller.
package nec_pkg;
  localparam int unsigned TapCount = 512;
  localparam int unsigned HistDepth = 4096;
  localparam int unsigned TapW = $clog2(TapCount);
  localparam int unsigned HistW = $clog2(HistDepth);
  localparam int unsigned TapCntW = $clog2(TapCount + 1);
  localparam int unsigned QDepth = 2;
  localparam logic [63:0] EnergyFloor = 64'd1073742;
  localparam int unsigned StepFrac = 43;
  localparam logic [47:0] StepMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [1:0] RegStep = 2'd0;
  localparam logic [1:0] RegDelay = 2'd1;
  localparam logic [1:0] RegLeak = 2'd2;

  typedef struct packed {
    logic signed [15:0] spk;
    logic signed [15:0] mic;
  } item_t;

  // Truncate a signed value right shift toward zero.
  function automatic logic signed [79:0] shr_tz(input logic signed [79:0] v,
                                                input int unsigned s);
    logic [79:0] m;
    m = v[79] ? (~v + 80'd1) : v;
    m = m >> s;
    return v[79] ? $signed(~m + 80'd1) : $signed(m);
  endfunction
endpackage

// ----- rtl/nlms_echo_canceller.sv -----
// NLMS echo canceller, 512 taps, 4096-sample far-end ring.
// Each beat makes one read pass over the 512 taps for the prediction and tap
// energy, a restoring division of 91 quotient bits for the step, and a second
// pass that rewrites every weight through the weight RAM port. After reset a
// clearing pass zeroes the history and weight RAMs; no input beat is taken
// until it ends. Two input beats queue while one is at work.
`include "nlms_echo_canceller_assert.svh"
module nlms_echo_canceller import nec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] speaker_sample_i,
  input  logic signed [15:0] mic_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] clean_sample_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [15:0] step_q, leak_q;
  logic [11:0] delay_q;
  logic        fr_ready, q_valid, q_pop, clearing;
  item_t       q_item, in_item;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  always_comb begin
    unique case (ridx)
      RegStep:  prdata = {16'd0, step_q};
      RegDelay: prdata = {20'd0, delay_q};
      RegLeak:  prdata = {16'd0, leak_q};
      default:  prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd328;
      delay_q <= 12'd2880;
      leak_q <= 16'd65529;
    end else if (psel && penable && pwrite) begin
      if (ridx == RegStep) step_q <= pwdata[15:0];
      if (ridx == RegDelay) delay_q <= pwdata[11:0];
      if (ridx == RegLeak) leak_q <= pwdata[15:0];
    end
  end

  assign in_item = '{spk: speaker_sample_i, mic: mic_sample_i};
  assign in_ready_o = fr_ready && !clearing;

  nec_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i && !clearing), .in_ready_o(fr_ready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );
  nec_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .step_size_i(step_q), .bulk_delay_i(delay_q), .leakage_i(leak_q),
    .out_valid_o, .out_ready_i, .out_sample_o(clean_sample_o), .clearing_o(clearing)
  );

  `NEC_ASSERT_IMP(a_no_in_clear, clk_i, rst_ni, clearing, !in_ready_o)
  `NEC_ASSERT_IMP(a_pop_valid, clk_i, rst_ni, q_pop, q_valid)
  `NEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

// ----- rtl/nec_ram.sv -----
// Generic single-port-write, registered-read RAM.
module nec_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/nec_front.sv -----
// Input queue that decouples the accept side from the adaptation engine.
module nec_front import nec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);
  item_t      buf_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

// ----- rtl/nec_divider.sv -----
// Restoring divider for the normalized step magnitude.
module nec_divider import nec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [47:0] quo_o
);
  // Compute floor(num*2^43/den) bit by bit over 91 quotient bits, saturating.
  localparam int unsigned NBits = 48 + StepFrac;
  logic [NBits-1:0] sh_q;
  logic [64:0]      rem_q;
  logic [63:0]      den_q;
  logic [47:0]      quo_q;
  logic             ovf_q, busy_q;
  logic [6:0]       cnt_q;
  logic [64:0]      trial;
  logic             bit_ok;

  assign trial = {rem_q[63:0], sh_q[NBits-1]};
  assign bit_ok = trial >= {1'b0, den_q};
  assign quo_o = (ovf_q || quo_q[47]) ? StepMax : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 7'(NBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= {num_i, StepFrac'(0)};
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      sh_q <= sh_q << 1;
      rem_q <= bit_ok ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[46:0], bit_ok};
      if (quo_q[47]) ovf_q <= 1'b1;
    end
  end
endmodule

// ----- rtl/nec_back.sv -----
// Adaptation engine: history write, filter pass, step division, update pass.
module nec_back import nec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  item_t              q_item_i,
  input  logic [15:0]        step_size_i,
  input  logic [11:0]        bulk_delay_i,
  input  logic [15:0]        leakage_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_sample_o,
  output logic               clearing_o
);
  typedef enum logic [2:0] {
    StClear, StIdle, StFilt, StDivStart, StDiv, StUpd, StOut
  } state_e;

  state_e              st_q;
  logic [HistW-1:0]    wpos_q, first_q, clr_q;
  logic [TapCntW-1:0]  ra_q;
  logic [TapCntW-1:0]  wa_q;
  logic                rv_q, mv_q;
  logic signed [15:0]  mic_q;
  logic signed [63:0]  acc_q;
  logic [63:0]         en_q;
  logic signed [31:0]  err_q;
  logic [47:0]         step_q;
  logic signed [47:0]  prod_q;
  logic signed [31:0]  xsq_q;
  logic signed [79:0]  lk_q, sx_q;
  logic                pv_q;

  logic                h_we, w_we;
  logic [HistW-1:0]    h_wa, h_ra;
  logic [15:0]         h_wd, h_rd;
  logic [TapW-1:0]     w_wa, w_ra;
  logic [31:0]         w_wd, w_rd;
  logic                div_start, div_done;
  logic [47:0]         div_q;
  logic [31:0]         err_abs;
  logic signed [47:0]  step_s;
  logic signed [79:0]  wsum;
  logic signed [31:0]  wsat;
  logic signed [63:0]  err_full;

  nec_ram #(.Width(16), .Depth(HistDepth)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );
  nec_ram #(.Width(32), .Depth(TapCount)) u_wts (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(w_wd), .raddr_i(w_ra), .rdata_o(w_rd)
  );

  assign err_abs = err_full[31] ? (~err_full[31:0] + 32'd1) : err_full[31:0];
  assign div_start = (st_q == StDivStart);
  nec_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(48'(step_size_i * err_abs)),
    .den_i(en_q), .done_o(div_done), .quo_o(div_q)
  );

  assign h_ra = first_q - HistW'(ra_q[TapW-1:0]);
  assign w_ra = ra_q[TapW-1:0];
  assign h_we = (st_q == StClear) || (st_q == StIdle && q_valid_i);
  assign h_wa = (st_q == StClear) ? clr_q : wpos_q;
  assign h_wd = (st_q == StClear) ? 16'd0 : q_item_i.spk;
  assign step_s = err_q[31] ? -$signed(step_q) : $signed(step_q);
  assign wsum = lk_q + sx_q;
  assign wsat = (wsum > 80'sd2147483647) ? 32'sh7FFF_FFFF :
                (wsum < -80'sd2147483648) ? 32'sh8000_0000 : wsum[31:0];
  assign w_we = (st_q == StClear) || (st_q == StUpd && pv_q);
  assign w_wa = (st_q == StClear) ? clr_q[TapW-1:0] : wa_q[TapW-1:0];
  assign w_wd = (st_q == StClear) ? 32'd0 : wsat;
  assign err_full = 64'(mic_q) - 64'(shr_tz(80'(acc_q), 28));
  assign q_pop_o = (st_q == StIdle) && q_valid_i;
  assign clearing_o = (st_q == StClear);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      wpos_q <= '0;
      out_valid_o <= 1'b0;
      ra_q <= '0;
      rv_q <= 1'b0;
      mv_q <= 1'b0;
      pv_q <= 1'b0;
      wa_q <= '0;
    end else begin
      unique case (st_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == HistW'(HistDepth - 1)) st_q <= StIdle;
        end
        StIdle: begin
          if (q_valid_i) begin
            first_q <= wpos_q - bulk_delay_i[HistW-1:0];
            mic_q <= q_item_i.mic;
            wpos_q <= wpos_q + 1'b1;
            acc_q <= '0;
            en_q <= EnergyFloor;
            ra_q <= '0;
            rv_q <= 1'b0;
            mv_q <= 1'b0;
            st_q <= StFilt;
          end
        end
        StFilt: begin
          rv_q <= (ra_q < TapCntW'(TapCount));
          if (ra_q < TapCntW'(TapCount)) ra_q <= ra_q + 1'b1;
          mv_q <= rv_q;
          if (rv_q) begin
            prod_q <= 48'($signed(w_rd) * $signed(h_rd));
            xsq_q <= $signed(h_rd) * $signed(h_rd);
          end
          if (mv_q) begin
            acc_q <= acc_q + 64'(prod_q);
            en_q <= en_q + 64'($unsigned(xsq_q));
          end
          if (!rv_q && mv_q && ra_q == TapCntW'(TapCount)) st_q <= StDivStart;
        end
        StDivStart: begin
          err_q <= err_full[31:0];
          st_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            step_q <= div_q;
            ra_q <= '0;
            rv_q <= 1'b0;
            pv_q <= 1'b0;
            wa_q <= '0;
            st_q <= StUpd;
          end
        end
        StUpd: begin
          rv_q <= (ra_q < TapCntW'(TapCount));
          if (ra_q < TapCntW'(TapCount)) ra_q <= ra_q + 1'b1;
          pv_q <= rv_q;
          if (rv_q) begin
            lk_q <= shr_tz(80'($signed(w_rd) * $signed({1'b0, leakage_i})), 16);
            sx_q <= shr_tz(80'(step_s * $signed(h_rd)), 31);
          end
          if (pv_q) wa_q <= wa_q + 1'b1;
          if (pv_q && !rv_q) begin
            out_valid_o <= 1'b1;
            out_sample_o <= (err_q > 32'sd32767) ? 16'sh7FFF :
                            (err_q < -32'sd32768) ? 16'sh8000 : err_q[15:0];
            st_q <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- tb/nec_checker.sv -----
// Echo canceller scoreboard: predicts every clean sample and compares it on the output.
`timescale 1ns / 100ps
module nec_checker import nec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] speaker_sample_i,
  input  logic signed [15:0] mic_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] clean_sample_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors_o,
  output int                 pending_o
);
  shortint              far_hist [HistDepth];
  int                   weights [TapCount];
  int unsigned          wr_pos;
  logic [15:0]          mu;
  logic [15:0]          leak;
  logic [11:0]          delay;
  logic signed [15:0]   clean_q [$];

  function automatic longint trunc_shr(longint v, int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  function automatic logic signed [15:0] cancel_echo(logic signed [15:0] spk,
                                                     logic signed [15:0] mic);
    longint       acc;
    longint       err;
    longint       step;
    longint       w;
    longint       x;
    logic [63:0]  energy;
    logic [63:0]  mag;
    logic [127:0] quo;
    int unsigned  first;
    far_hist[wr_pos] = spk;
    first = (wr_pos + HistDepth - delay) % HistDepth;
    acc = 0;
    energy = EnergyFloor;
    for (int i = 0; i < TapCount; i++) begin
      x = far_hist[(first + HistDepth - i) % HistDepth];
      acc += longint'(weights[i]) * x;
      energy += 64'(x * x);
    end
    err = longint'(mic) - trunc_shr(acc, 28);
    mag = 64'(mu) * 64'((err < 0) ? -err : err);
    quo = ({64'd0, mag} << StepFrac) / {64'd0, energy};
    if (quo > {80'd0, StepMax}) quo = {80'd0, StepMax};
    step = (err < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    for (int i = 0; i < TapCount; i++) begin
      x = far_hist[(first + HistDepth - i) % HistDepth];
      w = trunc_shr(longint'(weights[i]) * longint'({48'd0, leak}), 16)
          + trunc_shr(step * x, 31);
      if (w > 64'sd2147483647) w = 64'sd2147483647;
      if (w < -64'sd2147483648) w = -64'sd2147483648;
      weights[i] = int'(w);
    end
    wr_pos = (wr_pos + 1) % HistDepth;
    if (err > 32767) return 16'sh7FFF;
    if (err < -32768) return 16'sh8000;
    return err[15:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (far_hist[i]) far_hist[i] = 0;
      foreach (weights[i]) weights[i] = 0;
      wr_pos = 0;
      mu = 16'd328;
      delay = 12'd2880;
      leak = 16'd65529;
      clean_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegStep:  mu = pwdata[15:0];
          RegDelay: delay = pwdata[11:0];
          RegLeak:  leak = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (clean_q.size() == 0) begin
          report_mismatch("unexpected clean beat", clean_sample_i, 0);
        end else if (clean_sample_i !== clean_q[0]) begin
          report_mismatch("clean_sample", clean_sample_i, clean_q[0]);
          void'(clean_q.pop_front());
        end else begin
          void'(clean_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        clean_q.push_back(cancel_echo(speaker_sample_i, mic_sample_i));
      end
      pending_o = clean_q.size();
    end
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top for the echo canceller: stimulus, register setup and verdict.
`timescale 1ns / 100ps
module tb import nec_pkg::*;;
  localparam logic [3:0] AddrStep = {RegStep, 2'b00};
  localparam logic [3:0] AddrDelay = {RegDelay, 2'b00};
  localparam logic [3:0] AddrLeak = {RegLeak, 2'b00};
  localparam logic [3:0] AddrUnused = 4'd12;
  localparam int HoldCycles = 5000;
  localparam int Drain = 1300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] speaker_sample_i = '0;
  logic signed [15:0] mic_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] clean_sample_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  bit                 hold_req = 1'b0;
  logic signed [15:0] last_spk = '0;

  always #2 clk_i = ~clk_i;

  nlms_echo_canceller i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .speaker_sample_i, .mic_sample_i,
    .out_valid_o, .out_ready_i, .clean_sample_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nec_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .speaker_sample_i,
    .mic_sample_i, .out_valid_i(out_valid_o), .out_ready_i, .clean_sample_i(clean_sample_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(logic signed [15:0] spk, logic signed [15:0] mic);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    speaker_sample_i <= spk;
    mic_sample_i <= mic;
    last_spk = spk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_filter(logic [15:0] mu, logic [11:0] dly, logic [15:0] leak);
    reg_write(AddrStep, {$urandom} & 32'hFFFF_0000 | 32'(mu));
    reg_write(AddrDelay, 32'(dly));
    reg_write(AddrLeak, 32'(leak));
  endtask

  task automatic send_random();
    int                 pick;
    logic signed [15:0] spk;
    logic signed [15:0] mic;
    pick = $urandom_range(99);
    spk = 16'($urandom);
    if (pick < 70) begin
      mic = (last_spk >>> 1) + $signed(16'($urandom_range(0, 511)) - 16'sd256);
    end else if (pick < 85) begin
      mic = 16'($urandom);
    end else begin
      spk = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      mic = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    send_beat(spk, mic);
  endtask

  initial begin
    logic signed [15:0] edge_vals [4];
    edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 15;
    recv_idle = 88;
    reg_write(AddrUnused, 32'hFFFF_FFFF);
    set_filter(16'd65535, 12'd0, 16'd65535);
    foreach (edge_vals[i]) begin
      foreach (edge_vals[j]) send_beat(edge_vals[i], edge_vals[j]);
    end
    repeat (4) send_beat(16'sh7FFF, 16'sh8000);
    drain_results();
    set_filter(16'd0, 12'd4095, 16'd0);
    repeat (4) send_beat(16'($urandom), 16'($urandom));
    drain_results();
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 15 : (ph < 4) ? 88 : 0;
      recv_idle = (ph < 2) ? 88 : (ph < 4) ? 15 : 0;
      case (ph)
        0: set_filter(16'd328, 12'd2880, 16'd65529);
        1: set_filter(16'd20000, 12'd1, 16'd65500);
        2: set_filter(16'd65535, 12'd3584, 16'd65535);
        3: set_filter(16'd0, 12'd0, 16'd0);
        default: set_filter(16'($urandom), 12'($urandom_range(0, 40)),
                            16'($urandom_range(60000, 65535)));
      endcase
      for (int n = 0; n < 88; n++) begin
        if (ph == 4 && n == 10) hold_req = 1'b1;
        if (ph == 5 && n == 44) drain_results();
        send_random();
      end
      drain_results();
    end
    repeat (Drain) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
